// ===== design/bsws_pkg.sv =====
`timescale 1ns / 1ps
// Package for the bounded stack with search: sizes, mode and status codes,
// and the request and response beat types. No dependencies.
package bsws_pkg;

  localparam int DEPTH  = 64;
  localparam int ADDR_W = $clog2(DEPTH);
  localparam int CNT_W  = 7;
  localparam int WORD_W = 32;
  localparam int IDX_W  = 6;

  localparam logic [2:0] MODE_PUSH   = 3'd0;
  localparam logic [2:0] MODE_POP    = 3'd1;
  localparam logic [2:0] MODE_PEEK   = 3'd2;
  localparam logic [2:0] MODE_CLEAR  = 3'd3;
  localparam logic [2:0] MODE_SEARCH = 3'd4;

  localparam logic [1:0] STAT_OK    = 2'd0;
  localparam logic [1:0] STAT_FULL  = 2'd1;
  localparam logic [1:0] STAT_EMPTY = 2'd2;

  typedef struct packed {
    logic [2:0]               mode;
    logic signed [WORD_W-1:0] value;
  } req_t;

  typedef struct packed {
    logic [1:0]               status;
    logic signed [WORD_W-1:0] data;
    logic                     found;
    logic [IDX_W-1:0]         found_index;
    logic [CNT_W-1:0]         count;
    logic                     is_empty;
    logic                     is_full;
  } rsp_t;

endpackage

// ===== design/bsws_if.sv =====
`timescale 1ns / 1ps
// Handshake channel interfaces for requests, responses and configuration.
// Depends on bsws_pkg for the beat types.
interface bsws_req_if import bsws_pkg::*; ();
  logic valid;
  logic ready;
  req_t payload;
  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

interface bsws_rsp_if import bsws_pkg::*; ();
  logic valid;
  logic ready;
  rsp_t payload;
  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

interface bsws_cfg_if import bsws_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [CNT_W-1:0] capacity;
  modport source (output valid, output capacity, input ready);
  modport sink (input valid, input capacity, output ready);
endinterface

// ===== design/bounded_stack_with_search.sv =====
`timescale 1ns / 1ps
// Top level of the bounded stack with search: entry memory, control sequencer
// and response register. Depends on bsws_pkg and the interfaces in bsws_if.
//
//   channel  role   beat
//   req      sink   mode, value
//   rsp      source status, data, found, found_index, count, is_empty, is_full
//   cfg      sink   capacity
//
// Push, clear and unused modes finish on acceptance, and pop and peek first read the top entry
// unless the stack is empty. A search ends at once on an empty stack, else at the first match or
// after the bottom entry, since the single memory read port scans one entry per cycle from the top down.
// Reset empties the stack and sets the capacity to the full depth.
// A finished response waits in a holding register while the output stalls.
module bounded_stack_with_search import bsws_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  bsws_req_if.sink   req,
  bsws_rsp_if.source rsp,
  bsws_cfg_if.sink   cfg
);

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_READ = 4'b0010,
    ST_SCAN = 4'b0100,
    ST_EMIT = 4'b1000
  } state_t;

  localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(DEPTH);

  logic [WORD_W-1:0] mem [DEPTH];
  logic [WORD_W-1:0] rdata;
  logic [ADDR_W-1:0] raddr;
  logic              we;

  state_t            state, state_next;
  logic [CNT_W-1:0]  top, top_next;
  logic [CNT_W-1:0]  top_m1;
  logic [CNT_W-1:0]  cap;
  logic [WORD_W-1:0] key;
  logic [ADDR_W-1:0] scan_idx, scan_idx_next;
  rsp_t              res, res_next;
  rsp_t              out_data, out_data_next;
  logic              out_valid, out_valid_next;
  logic              out_free;
  logic              fin;
  rsp_t              fin_rsp;
  logic              accept;

  assign top_m1   = top - 1'b1;
  assign out_free = !out_valid || rsp.ready;
  assign req.ready = (state == ST_IDLE);
  assign accept   = req.valid && req.ready;
  assign cfg.ready = 1'b1;
  assign rsp.valid = out_valid;
  assign rsp.payload = out_data;

  // Accesses never overlap: one item is in flight and a push writes before any later read.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[top[ADDR_W-1:0]] <= req.payload.value;
    end
    rdata <= mem[raddr];
  end

  always_comb begin
    state_next     = state;
    top_next       = top;
    scan_idx_next  = scan_idx;
    res_next       = res;
    out_data_next  = out_data;
    out_valid_next = out_valid && !rsp.ready;
    we             = 1'b0;
    raddr          = top_m1[ADDR_W-1:0];
    fin            = 1'b0;
    fin_rsp        = '0;
    case (state)
      ST_IDLE: begin
        if (accept) begin
          case (req.payload.mode)
            MODE_PUSH: begin
              fin = 1'b1;
              if (top >= cap || top >= DEPTH_C) begin
                fin_rsp.status = STAT_FULL;
              end else begin
                we       = 1'b1;
                top_next = top + 1'b1;
              end
            end
            MODE_POP, MODE_PEEK: begin
              if (top == '0) begin
                fin            = 1'b1;
                fin_rsp.status = STAT_EMPTY;
              end else begin
                state_next = ST_READ;
                if (req.payload.mode == MODE_POP) begin
                  top_next = top_m1;
                end
              end
            end
            MODE_CLEAR: begin
              fin      = 1'b1;
              top_next = '0;
            end
            MODE_SEARCH: begin
              if (top == '0) begin
                fin = 1'b1;
              end else begin
                scan_idx_next = top_m1[ADDR_W-1:0];
                state_next    = ST_SCAN;
              end
            end
            default: begin
              fin = 1'b1;
            end
          endcase
        end
      end
      ST_READ: begin
        fin          = 1'b1;
        fin_rsp.data = rdata;
      end
      ST_SCAN: begin
        if (rdata == key) begin
          fin                 = 1'b1;
          fin_rsp.found       = 1'b1;
          fin_rsp.found_index = IDX_W'(scan_idx);
        end else if (scan_idx == '0) begin
          fin = 1'b1;
        end else begin
          scan_idx_next = scan_idx - 1'b1;
          raddr         = scan_idx - 1'b1;
        end
      end
      ST_EMIT: begin
        if (out_free) begin
          out_data_next  = res;
          out_valid_next = 1'b1;
          state_next     = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
    fin_rsp.count    = top_next;
    fin_rsp.is_empty = (top_next == '0);
    fin_rsp.is_full  = (top_next >= cap);
    if (fin) begin
      if (out_free) begin
        out_data_next  = fin_rsp;
        out_valid_next = 1'b1;
        state_next     = ST_IDLE;
      end else begin
        res_next   = fin_rsp;
        state_next = ST_EMIT;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      top       <= '0;
      cap       <= DEPTH_C;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      top       <= top_next;
      out_valid <= out_valid_next;
      if (cfg.valid && cfg.ready) begin
        cap <= (cfg.capacity > DEPTH_C) ? DEPTH_C : cfg.capacity;
      end
    end
  end

  always_ff @(posedge clk) begin
    scan_idx <= scan_idx_next;
    res      <= res_next;
    out_data <= out_data_next;
    if (accept) begin
      key <= req.payload.value;
    end
  end

  a_top_bound: assert property (@(posedge clk) disable iff (rst) top <= DEPTH_C)
    else $error("Stack pointer exceeds the depth.");

  a_push_grows: assert property (@(posedge clk) disable iff (rst)
    (accept && req.payload.mode == MODE_PUSH && top < cap) |=> top == $past(top) + 1'b1)
    else $error("Accepted push did not grow the stack.");

  a_full_flag: assert property (@(posedge clk) disable iff (rst)
    (rsp.valid && rsp.payload.status == STAT_FULL) |-> rsp.payload.is_full)
    else $error("Refused push reported without the full flag.");

  a_found_below: assert property (@(posedge clk) disable iff (rst)
    (rsp.valid && rsp.payload.found) |-> {1'b0, rsp.payload.found_index} < rsp.payload.count)
    else $error("Search hit lies above the top of the stack.");

endmodule
